@@ hdl/variable_width_glyph_layout_macros.svh @@
// assertion macros for the glyph layout block
`ifndef VARIABLE_WIDTH_GLYPH_LAYOUT_MACROS_SVH
`define VARIABLE_WIDTH_GLYPH_LAYOUT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define VWGL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define VWGL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/vwgl_pkg.sv @@
// shared types and constants for the glyph layout block
`timescale 1ns / 1ps
`default_nettype none
package vwgl_pkg;

  localparam int MAX_GLYPHS_DEF = 256;
  localparam int COORD_BITS_DEF = 16;

  localparam int FIELD_W  = 8;
  localparam int OUT_CW   = 16;
  localparam int OFFSET_W = 21;
  localparam int SUM_W    = 16;
  localparam int ROWS_W   = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_SET   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FONT_VALID   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_GAP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_GAP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT  = 3'd5;

  localparam logic [FIELD_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [FIELD_W-1:0] HEADER_BYTES = 8'd8;
  localparam logic [FIELD_W-1:0] ROW_ROUND    = 8'd7;

  typedef enum logic [1:0] {
    SU_IDLE,
    SU_READ,
    SU_DRAIN
  } sum_state_t;

  typedef enum logic {
    T_IDLE,
    T_SUM
  } top_state_t;

  typedef struct packed {
    logic               go;
    logic [FIELD_W-1:0] rel;
  } sum_req_t;

  typedef struct packed {
    logic               done;
    logic [SUM_W-1:0]   sum;
    logic [FIELD_W-1:0] width;
  } sum_rsp_t;

endpackage
`default_nettype wire

@@ hdl/vwgl_width_sum.sv @@
// glyph width memory with the sequential prefix-sum reader
`timescale 1ns / 1ps
`default_nettype none
`include "variable_width_glyph_layout_macros.svh"
module vwgl_width_sum #(
  parameter int MAX_GLYPHS = vwgl_pkg::MAX_GLYPHS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             load_en,
  input  wire [((MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1)-1:0] load_idx,
  input  wire [vwgl_pkg::FIELD_W-1:0]     load_val,
  input  vwgl_pkg::sum_req_t              req,
  output vwgl_pkg::sum_rsp_t              rsp
);

  localparam int IDX_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam int FW    = vwgl_pkg::FIELD_W;

  logic [FW-1:0] mem [MAX_GLYPHS];

  vwgl_pkg::sum_state_t state_r, state_nxt;
  logic [FW-1:0]               cnt_r, rel_r;
  logic [FW-1:0]               rd_data_r;
  logic                        rd_vld_r, rd_last_r, rd_oor_r;
  logic [vwgl_pkg::SUM_W-1:0]  sum_r;
  logic [FW-1:0]               width_r;
  logic                        done_r;

  logic          rd_en, rd_last;
  logic [FW-1:0] data_eff;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vwgl_pkg::SU_IDLE:  if (req.go) state_nxt = vwgl_pkg::SU_READ;
      vwgl_pkg::SU_READ:  if (rd_last) state_nxt = vwgl_pkg::SU_DRAIN;
      vwgl_pkg::SU_DRAIN: state_nxt = vwgl_pkg::SU_IDLE;
      default:            state_nxt = vwgl_pkg::SU_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    rd_en   = 1'b0;
    rd_last = 1'b0;
    unique case (state_r)
      vwgl_pkg::SU_READ: begin
        rd_en   = 1'b1;
        rd_last = (cnt_r == rel_r);
      end
      default: begin
        rd_en   = 1'b0;
        rd_last = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= vwgl_pkg::SU_IDLE;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= rd_en;
      rd_last_r <= rd_last;
      done_r    <= (state_r == vwgl_pkg::SU_DRAIN);
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      mem[load_idx] <= load_val;
    end
    rd_data_r <= mem[cnt_r[IDX_W-1:0]];
  end

  // entries past the table read as zero
  assign data_eff = rd_oor_r ? '0 : rd_data_r;

  always_ff @(posedge clk) begin
    rd_oor_r <= ({1'b0, cnt_r} >= (FW+1)'(MAX_GLYPHS));
    if (state_r == vwgl_pkg::SU_IDLE && req.go) begin
      cnt_r <= '0;
      rel_r <= req.rel;
      sum_r <= '0;
    end else begin
      if (rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (rd_vld_r) begin
        if (rd_last_r) begin
          width_r <= data_eff;
        end else begin
          sum_r <= sum_r + vwgl_pkg::SUM_W'(data_eff);
        end
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.sum   = sum_r;
  assign rsp.width = width_r;

  `VWGL_ASSERT_NOW(a_go_when_idle, req.go, state_r == vwgl_pkg::SU_IDLE, "sum request while busy")
  `VWGL_ASSERT_NOW(a_done_no_read, done_r, !rd_vld_r && !rd_en, "done with reads in flight")
  `VWGL_ASSERT_NEXT(a_drain_done, state_r == vwgl_pkg::SU_DRAIN, done_r && !rd_vld_r, "drain without done")

endmodule
`default_nettype wire

@@ hdl/variable_width_glyph_layout.sv @@
// top level: text cursor and glyph placement for a proportional bitmap font
//
// channel  direction  handshake            payload
// in_      input      start & !busy        operation, table index, width, code, new x/y
// out_     output     out_valid strobe     drawn flag, offset, width, draw x/y, cursor
// cfg_     input      cfg_we               six registers by cfg_index
//
// a glyph write reads the width memory once per cycle for entries 0..rel,
// rel = code - first_code; its result strobes once the width sum has drained and raised done
// every other transaction gives its result in the next cycle
// busy is high while the width sum runs; the result strobe cannot be stalled
// synchronous active-low reset clears cursor and registers; width memory is not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "variable_width_glyph_layout_macros.svh"
module variable_width_glyph_layout #(
  parameter int MAX_GLYPHS = vwgl_pkg::MAX_GLYPHS_DEF,
  parameter int COORD_BITS = vwgl_pkg::COORD_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  wire [1:0]                           in_operation,
  input  wire [vwgl_pkg::FIELD_W-1:0]         in_table_index,
  input  wire [vwgl_pkg::FIELD_W-1:0]         in_width_value,
  input  wire [vwgl_pkg::FIELD_W-1:0]         in_char_code,
  input  wire [vwgl_pkg::OUT_CW-1:0]          in_new_x,
  input  wire [vwgl_pkg::OUT_CW-1:0]          in_new_y,
  output logic                                out_valid,
  output logic                                out_glyph_drawn,
  output logic [vwgl_pkg::OFFSET_W-1:0]       out_glyph_offset,
  output logic [vwgl_pkg::FIELD_W-1:0]        out_glyph_width,
  output logic [vwgl_pkg::OUT_CW-1:0]         out_draw_x,
  output logic [vwgl_pkg::OUT_CW-1:0]         out_draw_y,
  output logic [vwgl_pkg::OUT_CW-1:0]         out_cursor_col,
  output logic [vwgl_pkg::OUT_CW-1:0]         out_cursor_row,
  input  wire                                 cfg_we,
  input  wire [vwgl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [vwgl_pkg::FIELD_W-1:0]         cfg_data
);

  localparam int IDX_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam int FW    = vwgl_pkg::FIELD_W;
  localparam int CW    = COORD_BITS;
  localparam int XW    = COORD_BITS + 2;
  localparam int PW    = vwgl_pkg::SUM_W + vwgl_pkg::ROWS_W;

  logic          font_valid_r;
  logic [FW-1:0] glyph_height_r, line_gap_r, char_gap_r, first_code_r, glyph_count_r;

  logic [CW-1:0] cx_r, cy_r;
  logic          gap_r;

  vwgl_pkg::top_state_t state_r, state_nxt;

  logic                              out_valid_r, out_drawn_r;
  logic [vwgl_pkg::OFFSET_W-1:0]     out_offset_r;
  logic [FW-1:0]                     out_width_r;
  logic [vwgl_pkg::OUT_CW-1:0]       out_dx_r, out_dy_r, out_col_r, out_row_r;

  vwgl_pkg::sum_req_t sum_req;
  vwgl_pkg::sum_rsp_t sum_rsp;

  logic          accept, in_font, go_sum, load_en;
  logic [FW:0]   font_end;
  logic [CW-1:0] cy_nl, cx_adv;
  logic [XW-1:0] cy_nl_full, cx_adv_full;
  logic [vwgl_pkg::ROWS_W-1:0] rows;
  logic [PW-1:0] prod;
  logic [PW-1:0] offset_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_valid_r   <= 1'b0;
      glyph_height_r <= '0;
      line_gap_r     <= '0;
      char_gap_r     <= '0;
      first_code_r   <= '0;
      glyph_count_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vwgl_pkg::REG_FONT_VALID:   font_valid_r   <= cfg_data[0];
        vwgl_pkg::REG_GLYPH_HEIGHT: glyph_height_r <= cfg_data;
        vwgl_pkg::REG_LINE_GAP:     line_gap_r     <= cfg_data;
        vwgl_pkg::REG_CHAR_GAP:     char_gap_r     <= cfg_data;
        vwgl_pkg::REG_FIRST_CODE:   first_code_r   <= cfg_data;
        vwgl_pkg::REG_GLYPH_COUNT:  glyph_count_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept   = start && !busy;
  assign font_end = {1'b0, first_code_r} + {1'b0, glyph_count_r};
  assign in_font  = (in_char_code >= first_code_r) && ({1'b0, in_char_code} < font_end);
  assign go_sum   = accept && (in_operation == vwgl_pkg::OP_WRITE) && font_valid_r
                    && (in_char_code != vwgl_pkg::NEWLINE_CODE) && in_font;
  assign load_en  = accept && (in_operation == vwgl_pkg::OP_LOAD)
                    && ({1'b0, in_table_index} < (FW+1)'(MAX_GLYPHS));

  assign sum_req.go  = go_sum;
  assign sum_req.rel = in_char_code - first_code_r;

  vwgl_width_sum #(
    .MAX_GLYPHS (MAX_GLYPHS)
  ) u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_en  (load_en),
    .load_idx (in_table_index[IDX_W-1:0]),
    .load_val (in_width_value),
    .req      (sum_req),
    .rsp      (sum_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vwgl_pkg::T_IDLE: if (go_sum) state_nxt = vwgl_pkg::T_SUM;
      vwgl_pkg::T_SUM:  if (sum_rsp.done) state_nxt = vwgl_pkg::T_IDLE;
      default:          state_nxt = vwgl_pkg::T_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    unique case (state_r)
      vwgl_pkg::T_IDLE: busy = 1'b0;
      default:          busy = 1'b1;
    endcase
  end

  assign cy_nl_full  = XW'(cy_r) + XW'(glyph_height_r) + XW'(line_gap_r);
  assign cy_nl       = cy_nl_full[CW-1:0];
  assign cx_adv_full = XW'(cx_r) + XW'(sum_rsp.width) + (gap_r ? XW'(char_gap_r) : '0);
  assign cx_adv      = cx_adv_full[CW-1:0];

  assign rows        = vwgl_pkg::ROWS_W'(({1'b0, glyph_height_r} + {1'b0, vwgl_pkg::ROW_ROUND}) >> 3);
  assign prod        = PW'(sum_rsp.sum) * PW'(rows);
  assign offset_full = prod + PW'(glyph_count_r) + PW'(vwgl_pkg::HEADER_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vwgl_pkg::T_IDLE;
      cx_r        <= '0;
      cy_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (accept && !go_sum) begin
        out_valid_r <= 1'b1;
        if (in_operation == vwgl_pkg::OP_SET) begin
          cx_r <= in_new_x[CW-1:0];
          cy_r <= in_new_y[CW-1:0];
        end else if (in_operation == vwgl_pkg::OP_WRITE && font_valid_r
                     && in_char_code == vwgl_pkg::NEWLINE_CODE) begin
          cx_r <= '0;
          cy_r <= cy_nl;
        end
      end else if (state_r == vwgl_pkg::T_SUM && sum_rsp.done) begin
        out_valid_r <= 1'b1;
        cx_r        <= cx_adv;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      gap_r <= !in_char_code[FW-1];
    end
    if (accept && !go_sum) begin
      out_drawn_r  <= 1'b0;
      out_offset_r <= '0;
      out_width_r  <= '0;
      out_dx_r     <= '0;
      out_dy_r     <= '0;
      if (in_operation == vwgl_pkg::OP_SET) begin
        out_col_r <= vwgl_pkg::OUT_CW'(in_new_x[CW-1:0]);
        out_row_r <= vwgl_pkg::OUT_CW'(in_new_y[CW-1:0]);
      end else if (in_operation == vwgl_pkg::OP_WRITE && font_valid_r
                   && in_char_code == vwgl_pkg::NEWLINE_CODE) begin
        out_col_r <= '0;
        out_row_r <= vwgl_pkg::OUT_CW'(cy_nl);
      end else begin
        out_col_r <= vwgl_pkg::OUT_CW'(cx_r);
        out_row_r <= vwgl_pkg::OUT_CW'(cy_r);
      end
    end else if (state_r == vwgl_pkg::T_SUM && sum_rsp.done) begin
      out_drawn_r  <= 1'b1;
      out_offset_r <= offset_full[vwgl_pkg::OFFSET_W-1:0];
      out_width_r  <= sum_rsp.width;
      out_dx_r     <= vwgl_pkg::OUT_CW'(cx_r);
      out_dy_r     <= vwgl_pkg::OUT_CW'(cy_r);
      out_col_r    <= vwgl_pkg::OUT_CW'(cx_adv);
      out_row_r    <= vwgl_pkg::OUT_CW'(cy_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_glyph_drawn  = out_drawn_r;
  assign out_glyph_offset = out_offset_r;
  assign out_glyph_width  = out_width_r;
  assign out_draw_x       = out_dx_r;
  assign out_draw_y       = out_dy_r;
  assign out_cursor_col   = out_col_r;
  assign out_cursor_row   = out_row_r;

  `VWGL_ASSERT_NOW(a_strobe_idle, out_valid_r, !busy, "result strobe while busy")
  `VWGL_ASSERT_NEXT(a_go_busy, go_sum, busy && !out_valid_r, "glyph write did not start sum")
  `VWGL_ASSERT_NEXT(a_done_strobe, sum_rsp.done, out_valid_r && out_drawn_r, "sum done without drawn result")
  `VWGL_ASSERT_NOW(a_blank_zero, out_valid_r && !out_drawn_r, out_offset_r == '0 && out_width_r == '0, "blank result with glyph data")

endmodule
`default_nettype wire
